>>> design/rcsd_pkg.sv
// Shared types and constants for the rank code stream decoder.
package rcsd_pkg;

  // Symbol given for a rank that has no table entry ('X')
  localparam logic [7:0] UNKNOWN_SYMBOL = 8'd88;
  // Symbol value that terminates a frame
  localparam logic [7:0] TERM_SYMBOL = 8'd0;

  // Stream parsing phase
  typedef enum logic [1:0] {
    PH_COUNT,
    PH_WIDTH,
    PH_SYMS,
    PH_BITS
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_READ,
    ST_FLUSH
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // take the input byte
    logic step;    // consume one content bit
    logic take;    // move the looked-up result into the pending slot
    logic flush;   // move the pending result out as the last of its byte
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic phase_bits;  // next byte is content
    logic hdr_emit;    // next header byte closes a width-zero header
    logic done;        // current bit completes a code
    logic bit_last;    // current bit is bit 0 of the byte
    logic byte_end;    // last completed code used bit 0, or header result
    logic eof_new;     // result being taken ends the frame
    logic p_valid;     // pending slot holds a result
    logic o_free;      // output register can load this cycle
  } dp_sts_t;

endpackage

>>> design/rank_code_stream_decoder_unit.sv
// Top level of the rank code stream decoder: controller plus datapath.
//
//   Channel | Ports                                               | Dir
//   --------+-----------------------------------------------------+-----
//   input   | in_valid, in_ready, in_stream_byte                  | in
//   result  | out_valid, out_ready, out_symbol, out_unknown_code, | out
//           | out_end_of_frame, out_last                          |
//
// A header byte is taken in the idle state; a header byte that closes a width-zero
// header also passes through a lookup and a flush. A content byte passes through
// an intake, a bit step per bit up to the terminator, a lookup per decoded code
// and a flush when it gave any result; the code reader takes one bit per cycle between lookups.
// A full output register holds the flush, and a lookup that has a result pending,
// until out_ready. Synchronous reset clears control state; the symbol table is not
// cleared and needs no clearing pass.
module rank_code_stream_decoder_unit
  import rcsd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 255,
  parameter int MAX_WIDTH   = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       out_unknown_code,
  output logic       out_end_of_frame,
  output logic       out_last
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  rcsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcsd_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_stream_byte   (in_stream_byte),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_symbol       (out_symbol),
    .out_unknown_code (out_unknown_code),
    .out_end_of_frame (out_end_of_frame),
    .out_last         (out_last)
  );

  // No result may be left pending when a new byte can be taken
  a_no_pending_at_intake: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.p_valid)
    else $error("pending result left behind at byte intake");

  // A frame end always closes its byte and is never an unknown code
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> (out_last && !out_unknown_code))
    else $error("frame end result not last or flagged unknown");

  // A completed code goes to lookup before any new byte
  a_done_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.done) |=> (!in_ready && !cmd.step))
    else $error("completed code skipped its lookup");

endmodule

>>> design/rcsd_ctrl.sv
// Controller state machine: sequences byte intake, bit steps, lookups and output.
module rcsd_ctrl
  import rcsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.phase_bits) begin
            state_nxt = ST_BIT;
          end else if (sts.hdr_emit) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_BIT: begin
        if (sts.done) begin
          state_nxt = ST_READ;
        end else if (sts.bit_last) begin
          state_nxt = sts.p_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_READ: begin
        if (!sts.p_valid || sts.o_free) begin
          state_nxt = (sts.eof_new || sts.byte_end) ? ST_FLUSH : ST_BIT;
        end
      end
      ST_FLUSH: begin
        if (sts.o_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_BIT: begin
        cmd.step = 1'b1;
      end
      ST_READ: begin
        cmd.take = !sts.p_valid || sts.o_free;
      end
      ST_FLUSH: begin
        cmd.flush = sts.o_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> design/rcsd_datapath.sv
// Datapath: header registers, symbol table, bit-serial code reader and result registers.
module rcsd_datapath
  import rcsd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 255,
  parameter int MAX_WIDTH   = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_cmd_t   cmd,
  output dp_sts_t    sts,
  input  logic [7:0] in_stream_byte,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_symbol,
  output logic       out_unknown_code,
  output logic       out_end_of_frame,
  output logic       out_last
);

  localparam int AW  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int LWW = $clog2(MAX_WIDTH + 1);
  localparam int CW  = MAX_WIDTH;
  localparam int OW  = (1 << MAX_WIDTH) - 1;
  localparam int RW  = OW + 1;
  localparam int KW  = (RW > 9) ? RW : 9;

  // Header state
  phase_t           phase_r, phase_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [LWW-1:0]   lw_r, lw_nxt;
  logic [7:0]       hi_r, hi_nxt;

  // Code reader state
  logic             stage_r, stage_nxt;
  logic [CW-1:0]    bc_r, bc_nxt;
  logic [CW-1:0]    la_r, la_nxt;
  logic [OW-1:0]    off_r, off_nxt;

  // Current content byte
  logic [7:0]       byte_r, byte_nxt;
  logic [2:0]       bidx_r, bidx_nxt;
  logic             byte_end_r, byte_end_nxt;

  // Lookup flags
  logic             unk_r, unk_nxt;
  logic             term_r, term_nxt;

  // Symbol table
  logic [7:0]       mem [MAX_SYMBOLS];
  logic [7:0]       mem_q_r;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;

  // Pending result and output register
  logic             p_vld_r, p_vld_nxt;
  logic [7:0]       p_sym_r, p_sym_nxt;
  logic             p_unk_r, p_unk_nxt;
  logic             p_eof_r, p_eof_nxt;
  logic             o_vld_r, o_vld_nxt;
  logic [7:0]       o_sym_r, o_sym_nxt;
  logic             o_unk_r, o_unk_nxt;
  logic             o_eof_r, o_eof_nxt;
  logic             o_last_r, o_last_nxt;

  // Combinational helpers
  logic [7:0]       hi_inc;
  logic             hdr_final;
  logic [LWW-1:0]   lw_clip;
  logic             bit_c;
  logic [CW:0]      la_ext;
  logic [CW-1:0]    la_step;
  logic [OW-1:0]    off_step;
  logic [CW-1:0]    bc_inc;
  logic             len_end;
  logic             done_c;
  logic [CW-1:0]    la_use;
  logic [RW-1:0]    rank_c;
  logic [KW-1:0]    rank_k;
  logic             known_c;
  logic [7:0]       res_sym;
  logic             res_eof;
  logic             o_free;

  // Header arithmetic
  always_comb begin
    hi_inc    = hi_r + 8'd1;
    hdr_final = (hi_inc >= count_r) || (hi_inc == 8'd0);
    lw_clip   = (in_stream_byte > 8'(MAX_WIDTH)) ? LWW'(MAX_WIDTH)
                                                 : in_stream_byte[LWW-1:0];
  end

  // One content bit through the length or offset field
  always_comb begin
    bit_c  = byte_r[bidx_r];
    la_ext = {la_r, bit_c};
    bc_inc = bc_r + CW'(1);
    if (!stage_r) begin
      la_step  = la_ext[CW-1:0];
      off_step = off_r;
      len_end  = bc_inc >= CW'(lw_r);
      done_c   = len_end && (la_step == '0);
      la_use   = '0;
    end else begin
      la_step  = la_r;
      off_step = off_r | (OW'(bit_c) << bc_r);
      len_end  = 1'b0;
      done_c   = bc_inc >= la_r;
      la_use   = la_r;
    end
    rank_c  = ((RW'(1) << la_use) - RW'(1)) + RW'(off_step);
    rank_k  = KW'(rank_c);
    known_c = (rank_k < KW'(count_r)) && (rank_k < KW'(MAX_SYMBOLS));
  end

  // Result formed from the lookup
  always_comb begin
    res_sym = unk_r ? UNKNOWN_SYMBOL : mem_q_r;
    res_eof = term_r || (!unk_r && (mem_q_r == TERM_SYMBOL));
    o_free  = !o_vld_r || out_ready;
  end

  // Next-state logic for all registers
  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    lw_nxt       = lw_r;
    hi_nxt       = hi_r;
    stage_nxt    = stage_r;
    bc_nxt       = bc_r;
    la_nxt       = la_r;
    off_nxt      = off_r;
    byte_nxt     = byte_r;
    bidx_nxt     = bidx_r;
    byte_end_nxt = byte_end_r;
    unk_nxt      = unk_r;
    term_nxt     = term_r;
    wr_en        = 1'b0;
    wr_addr      = hi_r[AW-1:0];
    rd_en        = 1'b0;
    rd_addr      = '0;
    p_vld_nxt    = p_vld_r;
    p_sym_nxt    = p_sym_r;
    p_unk_nxt    = p_unk_r;
    p_eof_nxt    = p_eof_r;
    o_vld_nxt    = o_vld_r && !out_ready;
    o_sym_nxt    = o_sym_r;
    o_unk_nxt    = o_unk_r;
    o_eof_nxt    = o_eof_r;
    o_last_nxt   = o_last_r;

    if (cmd.accept) begin
      // Header bytes update in place; content bytes are latched
      unique case (phase_r)
        PH_COUNT: begin
          count_nxt = in_stream_byte;
          hi_nxt    = 8'd0;
          if (in_stream_byte != 8'd0) begin
            phase_nxt = PH_WIDTH;
          end
        end
        PH_WIDTH: begin
          lw_nxt    = lw_clip;
          phase_nxt = PH_SYMS;
        end
        PH_SYMS: begin
          wr_en        = hi_r < 8'(MAX_SYMBOLS);
          hi_nxt       = hi_inc;
          byte_end_nxt = 1'b1;
          if (hdr_final) begin
            stage_nxt = 1'b0;
            bc_nxt    = '0;
            la_nxt    = '0;
            off_nxt   = '0;
            if (lw_r == '0) begin
              rd_en     = 1'b1;
              unk_nxt   = 1'b0;
              term_nxt  = 1'b1;
              phase_nxt = PH_COUNT;
            end else begin
              phase_nxt = PH_BITS;
            end
          end
        end
        PH_BITS: begin
          byte_nxt     = in_stream_byte;
          bidx_nxt     = 3'd7;
          byte_end_nxt = 1'b0;
        end
        default: phase_nxt = PH_COUNT;
      endcase
    end else if (cmd.step) begin
      // Advance one bit; start the lookup when a code completes
      bidx_nxt     = bidx_r - 3'd1;
      byte_end_nxt = (bidx_r == 3'd0);
      if (done_c) begin
        stage_nxt = 1'b0;
        bc_nxt    = '0;
        la_nxt    = '0;
        off_nxt   = '0;
        unk_nxt   = !known_c;
        term_nxt  = 1'b0;
        rd_en     = known_c;
        rd_addr   = rank_k[AW-1:0];
      end else if (!stage_r) begin
        la_nxt = la_step;
        if (len_end) begin
          bc_nxt    = '0;
          stage_nxt = 1'b1;
        end else begin
          bc_nxt = bc_inc;
        end
      end else begin
        off_nxt = off_step;
        bc_nxt  = bc_inc;
      end
    end else if (cmd.take) begin
      // Push the older pending result out, hold the new one
      if (p_vld_r) begin
        o_vld_nxt  = 1'b1;
        o_sym_nxt  = p_sym_r;
        o_unk_nxt  = p_unk_r;
        o_eof_nxt  = p_eof_r;
        o_last_nxt = 1'b0;
      end
      p_vld_nxt = 1'b1;
      p_sym_nxt = res_sym;
      p_unk_nxt = unk_r;
      p_eof_nxt = res_eof;
      if (res_eof) begin
        phase_nxt = PH_COUNT;
      end
    end else if (cmd.flush) begin
      // Release the final result of the byte
      o_vld_nxt  = 1'b1;
      o_sym_nxt  = p_sym_r;
      o_unk_nxt  = p_unk_r;
      o_eof_nxt  = p_eof_r;
      o_last_nxt = 1'b1;
      p_vld_nxt  = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      count_r <= '0;
      lw_r    <= '0;
      hi_r    <= '0;
      stage_r <= 1'b0;
      bc_r    <= '0;
      la_r    <= '0;
      off_r   <= '0;
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      lw_r    <= lw_nxt;
      hi_r    <= hi_nxt;
      stage_r <= stage_nxt;
      bc_r    <= bc_nxt;
      la_r    <= la_nxt;
      off_r   <= off_nxt;
      p_vld_r <= p_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    bidx_r     <= bidx_nxt;
    byte_end_r <= byte_end_nxt;
    unk_r      <= unk_nxt;
    term_r     <= term_nxt;
    p_sym_r    <= p_sym_nxt;
    p_unk_r    <= p_unk_nxt;
    p_eof_r    <= p_eof_nxt;
    o_sym_r    <= o_sym_nxt;
    o_unk_r    <= o_unk_nxt;
    o_eof_r    <= o_eof_nxt;
    o_last_r   <= o_last_nxt;
  end

  // Symbol table: one write port, one registered read port with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_stream_byte;
    end
    if (rd_en) begin
      mem_q_r <= (wr_en && (wr_addr == rd_addr)) ? in_stream_byte : mem[rd_addr];
    end
  end

  // Status to controller
  always_comb begin
    sts.phase_bits = (phase_r == PH_BITS);
    sts.hdr_emit   = (phase_r == PH_SYMS) && hdr_final && (lw_r == '0);
    sts.done       = done_c;
    sts.bit_last   = (bidx_r == 3'd0);
    sts.byte_end   = byte_end_r;
    sts.eof_new    = res_eof;
    sts.p_valid    = p_vld_r;
    sts.o_free     = o_free;
  end

  assign out_valid        = o_vld_r;
  assign out_symbol       = o_sym_r;
  assign out_unknown_code = o_unk_r;
  assign out_end_of_frame = o_eof_r;
  assign out_last         = o_last_r;

endmodule

>>> verif/rank_code_stream_decoder_unit_tb.sv
// Self-checking testbench for the rank code stream decoder: header and coded-frame stimulus.
`timescale 1ns / 100ps

module rank_code_stream_decoder_unit_tb;
  import rcsd_pkg::*;

  localparam int MAX_SYM      = 255;
  localparam int MAX_W        = 4;
  localparam int ITEM_TARGET  = 470;
  localparam int HOLD_AT      = 60;    // result count at which the receiver holds off
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;  // idle cycles tolerated; well above hold plus stalls
  localparam int DRAIN_CYCLES = 40;    // worst byte latency plus one receiver stall
  localparam int CHK_CTX      = 0;     // decoder copy fed by accepted transfers
  localparam int GEN_CTX      = 1;     // decoder copy that tracks the generated stream

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  count;
    logic [2:0]  lwidth;
    logic [7:0]  hidx;
    logic        fstage;
    logic [3:0]  bitcnt;
    logic [3:0]  lacc;
    logic [14:0] oacc;
  } dec_ctx_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       unknown;
    logic       eof;
    logic       last;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_stream_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_symbol;
  logic       out_unknown_code;
  logic       out_end_of_frame;
  logic       out_last;

  dec_ctx_t    dec_ctx [2];
  logic [7:0]  sym_tbl [2][MAX_SYM];
  logic [7:0]  pending_bytes [$];
  dec_result_t expected_syms [$];
  logic        frame_bits [$];

  int          n_items = 0;
  int          err_cnt = 0;
  int          in_gap = 0;
  logic        in_calm = 1'b0;
  int          rx_stall = 0;
  int          rx_count = 0;
  logic        rx_calm = 1'b0;
  int          rx_wait;
  dec_result_t want;
  int          idle_cycles = 0;

  rank_code_stream_decoder_unit #(
    .MAX_SYMBOLS(MAX_SYM),
    .MAX_WIDTH  (MAX_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_stream_byte  (in_stream_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_unknown_code(out_unknown_code),
    .out_end_of_frame(out_end_of_frame),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // Drop any partial code
  function automatic dec_ctx_t code_cleared(dec_ctx_t c);
    c.fstage = 1'b0;
    c.bitcnt = '0;
    c.lacc   = '0;
    c.oacc   = '0;
    return c;
  endfunction

  // Advance one decoder copy by one stream byte; the checking copy queues its results
  function automatic void decode_stream_byte(input int who, input logic [7:0] b);
    dec_ctx_t    s;
    dec_result_t res [8];
    dec_result_t r;
    int          n;
    int          i;
    int          k;
    logic        done;
    logic        stop;
    int unsigned rank;
    logic [7:0]  sym;
    s = dec_ctx[who];
    n = 0;
    stop = 1'b0;
    case (s.phase)
      PH_COUNT: begin
        s.count = b;
        s.hidx = '0;
        if (b != 8'd0) s.phase = PH_WIDTH;
      end
      PH_WIDTH: begin
        s.lwidth = (b > 8'(MAX_W)) ? 3'(MAX_W) : b[2:0];
        s.phase = PH_SYMS;
      end
      PH_SYMS: begin
        if (s.hidx < 8'(MAX_SYM)) sym_tbl[who][s.hidx] = b;
        s.hidx = s.hidx + 8'd1;
        if (s.hidx >= s.count || s.hidx == 8'd0) begin
          s = code_cleared(s);
          // width zero: the header itself yields entry 0 and closes the frame
          if (s.lwidth == 3'd0) begin
            res[0] = {sym_tbl[who][0], 1'b0, 1'b1, 1'b0};
            n = 1;
            s.phase = PH_COUNT;
          end else begin
            s.phase = PH_BITS;
          end
        end
      end
      default: begin
        for (i = 7; i >= 0 && !stop; i--) begin
          done = 1'b0;
          if (!s.fstage) begin
            // length field, MSB first
            s.lacc = {s.lacc[2:0], b[i]};
            s.bitcnt = s.bitcnt + 4'd1;
            if (s.bitcnt >= {1'b0, s.lwidth}) begin
              s.bitcnt = '0;
              if (s.lacc == 4'd0) done = 1'b1;
              else s.fstage = 1'b1;
            end
          end else begin
            // offset field, LSB first
            s.oacc = s.oacc | (15'(b[i]) << s.bitcnt);
            s.bitcnt = s.bitcnt + 4'd1;
            if (s.bitcnt >= s.lacc) done = 1'b1;
          end
          if (done) begin
            rank = (32'd1 << s.lacc) - 32'd1 + 32'(s.oacc);
            if (rank < 32'(s.count) && rank < MAX_SYM) begin
              sym = sym_tbl[who][rank];
              res[n] = {sym, 1'b0, (sym == TERM_SYMBOL), 1'b0};
              // terminator ends the frame and discards the rest of the byte
              if (sym == TERM_SYMBOL) begin
                s.phase = PH_COUNT;
                stop = 1'b1;
              end
            end else begin
              res[n] = {UNKNOWN_SYMBOL, 1'b1, 1'b0, 1'b0};
            end
            n++;
            s = code_cleared(s);
          end
        end
      end
    endcase
    dec_ctx[who] = s;
    if (who == CHK_CTX) begin
      for (k = 0; k < n; k++) begin
        r = res[k];
        r.last = (k == n - 1);
        expected_syms.push_back(r);
      end
    end
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    decode_stream_byte(GEN_CTX, b);
    n_items++;
  endtask

  // Append one code: length field MSB first, then offset LSB first
  task automatic queue_rank_code(input int rank, input int w);
    int len;
    int off;
    int k;
    len = 0;
    while (((1 << (len + 1)) - 1) <= rank) len++;
    off = rank - ((1 << len) - 1);
    for (k = w - 1; k >= 0; k--) frame_bits.push_back(len[k]);
    for (k = 0; k < len; k++) frame_bits.push_back(off[k]);
  endtask

  // Well-formed frame: header, random codes, then the terminator's code
  task automatic queue_frame(input int count, input int wbyte, input int n_codes,
                             input int unk_pct);
    int         w;
    int         maxr;
    int         lmax;
    int         top;
    int         t;
    int         k;
    int         j;
    int         r;
    int         len;
    int         lo;
    int         hi;
    logic [7:0] b;
    w = (wbyte > MAX_W) ? MAX_W : wbyte;
    maxr = (w == 0) ? 0 : (1 << (1 << w)) - 2;
    lmax = (1 << w) - 1;
    // highest rank that is both in the table and codable at this width
    top = ((count - 1) < maxr) ? count - 1 : maxr;
    t = $urandom_range(0, top);
    queue_byte(8'(count));
    queue_byte(8'(wbyte));
    for (k = 0; k < count; k++) begin
      if (w == 0) queue_byte(8'($urandom_range(0, 255)));
      else if (k == t) queue_byte(TERM_SYMBOL);
      else queue_byte(8'($urandom_range(1, 255)));
    end
    if (w != 0) begin
      for (k = 0; k < n_codes; k++) begin
        if (count > 1 && (count > maxr || $urandom_range(0, 99) >= unk_pct)) begin
          // known rank other than the terminator
          r = $urandom_range(0, top - 1);
          if (r >= t) r++;
        end else begin
          // rank past the table: pick a length, then an offset beyond the count
          len = $urandom_range(0, lmax);
          lo = (1 << len) - 1;
          hi = (1 << (len + 1)) - 2;
          if (hi < count) r = $urandom_range(count, maxr);
          else r = $urandom_range((lo < count) ? count : lo, hi);
        end
        queue_rank_code(r, w);
      end
      queue_rank_code(t, w);
      // pack MSB first, pad the tail with random bits
      while (frame_bits.size() > 0) begin
        for (j = 7; j >= 0; j--) begin
          if (frame_bits.size() > 0) b[j] = frame_bits.pop_front();
          else b[j] = 1'($urandom_range(0, 1));
        end
        queue_byte(b);
      end
    end
  endtask

  // Build the whole stream up front
  initial begin
    int   sel;
    int   count;
    int   wsel;
    int   wbyte;
    int   k;
    int   guard;
    logic big_done;
    dec_ctx[CHK_CTX] = '0;
    dec_ctx[GEN_CTX] = '0;
    big_done = 1'b0;

    // empty frame
    queue_byte(8'd0);
    // width zero: entry 0 emitted and ends the frame, zero or not
    queue_byte(8'd1); queue_byte(8'd0); queue_byte(8'd0);
    queue_byte(8'd2); queue_byte(8'd0); queue_byte(8'hFF); queue_byte(8'h7E);
    // eight zero-length codes in one byte, then terminator with the rest dropped
    queue_byte(8'd3); queue_byte(8'd1);
    queue_byte(8'h5A); queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'h00); queue_byte(8'hBF);
    // width byte above the maximum, unknown codes
    queue_frame(2, 255, 3, 60);

    while (n_items < ITEM_TARGET) begin
      sel = $urandom_range(0, 19);
      if (!big_done && n_items > 150) begin
        // full table
        queue_frame(255, 4, 12, 20);
        big_done = 1'b1;
      end else if (sel == 0) begin
        queue_byte(8'd0);
      end else if (sel <= 2) begin
        // broken frame: random content, then zeros until entry 0 terminates it
        count = $urandom_range(1, 12);
        queue_byte(8'(count));
        queue_byte(8'($urandom_range(1, 255)));
        queue_byte(TERM_SYMBOL);
        for (k = 1; k < count; k++) queue_byte(8'($urandom_range(0, 255)));
        guard = $urandom_range(1, 6);
        while (dec_ctx[GEN_CTX].phase == PH_BITS && guard > 0) begin
          queue_byte(8'($urandom_range(0, 255)));
          guard--;
        end
        while (dec_ctx[GEN_CTX].phase == PH_BITS) queue_byte(8'h00);
      end else begin
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        wsel = $urandom_range(0, 19);
        if (wsel == 0) wbyte = 0;
        else if (wsel <= 3) wbyte = $urandom_range(5, 255);
        else wbyte = $urandom_range(1, 4);
        queue_frame(count, wbyte, $urandom_range(0, 10), 20);
      end
    end
  end

  // Hold reset, then wait for the stream to drain; sample between edges
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (expected_syms.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[rank_code_stream_decoder_unit] OK");
    end else begin
      $display("[rank_code_stream_decoder_unit] ERROR");
    end
    $finish;
  end

  // Driver: predict on each input transfer, then offer the next byte after a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) decode_stream_byte(CHK_CTX, in_stream_byte);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_stream_byte <= pending_bytes.pop_front();
          if ($urandom_range(0, 29) == 0) in_calm <= !in_calm;
          in_gap <= in_calm ? 0 : $urandom_range(0, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer, then stall the receiver at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_syms.size() == 0) begin
        $error("unexpected result: symbol %0d", out_symbol);
        err_cnt++;
      end else begin
        want = expected_syms.pop_front();
        if (out_symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, out_symbol);
          err_cnt++;
        end
        if (out_unknown_code !== want.unknown) begin
          $error("unknown_code: expected %0d, got %0d", want.unknown, out_unknown_code);
          err_cnt++;
        end
        if (out_end_of_frame !== want.eof) begin
          $error("end_of_frame: expected %0d, got %0d", want.eof, out_end_of_frame);
          err_cnt++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          err_cnt++;
        end
      end
      rx_count++;
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
      // one long hold-off so the block backs up into its input
      if (rx_count == HOLD_AT) rx_wait = HOLD_CYCLES;
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_stall <= rx_wait;
      end
    end else if (rx_stall > 1) begin
      rx_stall <= rx_stall - 1;
    end else begin
      rx_stall <= 0;
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[rank_code_stream_decoder_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
